// File: rtl/ise_pkg.sv
// Shared types and constants for the insertion sort engine.
package ise_pkg;

   // Width of the value fields on the item ports.
   localparam int VAL_FIELD_W = 32;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;   // place the broadcast value into the chain
      logic drain;    // shift every entry one cell toward the head
   } ise_ctrl_type;

endpackage

// File: rtl/ise_cell.sv
// One cell of the sorting chain: holds one stored value, compares and shifts.
module ise_cell #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  ise_pkg::ise_ctrl_type     ctrl,
   input  logic                      occupied,
   input  logic signed [WIDTH-1:0]   new_value,
   input  logic                      prev_greater,
   input  logic signed [WIDTH-1:0]   prev_value,
   input  logic signed [WIDTH-1:0]   next_value,
   output logic                      greater,
   output logic signed [WIDTH-1:0]   value
);
   import ise_pkg::*;

   logic signed [WIDTH-1:0] value_ff;
   logic signed [WIDTH-1:0] value_in;

   // An empty cell counts as larger than anything, so the new value lands
   // at the first free slot when nothing held is larger.
   assign greater = !occupied || (value_ff > new_value);
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (greater) begin
            value_in = prev_greater ? prev_value : new_value;
         end
      end else if (ctrl.drain) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: rtl/insertion_sort_engine_core.sv
// Top level of the insertion sort engine: cell chain, fill count and output register.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+--------------------------------------
//  req     | in        | req_valid/req_stall| req_value, req_last
//  rsp     | out       | rsp_valid/rsp_stall| rsp_sorted_value, rsp_end_of_run,
//          |           |                    | rsp_overflow
//
// While collecting, one item is taken every cycle: all cells compare against
// the incoming value and shift in the same cycle.
// After an item marked last, the n stored values leave one per cycle from the
// head cell while rsp_stall lets them; req_stall stays high until the last has left.
// Reset empties the chain (count to zero) and clears the dropped-item flag behind rsp_overflow.
// rsp_stall only holds the output register; the chain waits for it to free up.
module insertion_sort_engine_core #(
   parameter int DEPTH       = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ise_pkg::VAL_FIELD_W-1:0] req_value,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ise_pkg::VAL_FIELD_W-1:0] rsp_sorted_value,
   output logic                                   rsp_end_of_run,
   output logic                                   rsp_overflow
);
   import ise_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   state_type                      state_ff;
   logic [CW-1:0]                  count_ff;
   logic                           dropped_ff;
   logic                           rsp_valid_ff;
   logic signed [VAL_FIELD_W-1:0]  rsp_value_ff;
   logic                           rsp_eor_ff;
   logic                           rsp_ovf_ff;

   logic                           accept;
   logic                           full;
   logic                           take;
   ise_ctrl_type                   ctrl;
   logic signed [VALUE_WIDTH-1:0]  new_value;
   logic signed [VAL_FIELD_W-1:0]  head_value;

   logic                           greater [DEPTH];
   logic signed [VALUE_WIDTH-1:0]  cell_value [DEPTH];

   assign req_stall = (state_ff != ST_COLLECT);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(DEPTH));
   assign take      = !rsp_valid_ff || !rsp_stall;

   assign ctrl.insert = accept && !full;
   assign ctrl.drain  = (state_ff == ST_DRAIN) && take;

   // Drop field bits above the stored width; widen with zeros otherwise.
   if (VALUE_WIDTH <= VAL_FIELD_W) begin : g_in_narrow
      assign new_value = req_value[VALUE_WIDTH-1:0];
   end else begin : g_in_wide
      assign new_value = {{(VALUE_WIDTH - VAL_FIELD_W){1'b0}}, req_value};
   end

   if (VALUE_WIDTH < VAL_FIELD_W) begin : g_out_narrow
      assign head_value = {{(VAL_FIELD_W - VALUE_WIDTH){1'b0}}, cell_value[0]};
   end else begin : g_out_wide
      assign head_value = cell_value[0][VAL_FIELD_W-1:0];
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                          prev_g;
      logic signed [VALUE_WIDTH-1:0] prev_v;
      logic signed [VALUE_WIDTH-1:0] next_v;

      if (i == 0) begin : g_head
         assign prev_g = 1'b0;
         assign prev_v = new_value;
      end else begin : g_body
         assign prev_g = greater[i-1];
         assign prev_v = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_v = cell_value[i];
      end else begin : g_link
         assign next_v = cell_value[i+1];
      end

      ise_cell #(
         .WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (CW'(i) < count_ff),
         .new_value    (new_value),
         .prev_greater (prev_g),
         .prev_value   (prev_v),
         .next_value   (next_v),
         .greater      (greater[i]),
         .value        (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_COLLECT: begin
               if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  if (full) begin
                     dropped_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CW'(1);
                  end
                  if (req_last) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (take) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= head_value;
                  rsp_eor_ff   <= (count_ff == CW'(1));
                  rsp_ovf_ff   <= dropped_ff;
                  count_ff     <= count_ff - CW'(1);
                  // last entry out: close the set
                  if (count_ff == CW'(1)) begin
                     dropped_ff <= 1'b0;
                     state_ff   <= ST_COLLECT;
                  end
               end
            end
            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_run   = rsp_eor_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("draining an empty chain");

   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && full) |=> dropped_ff || (state_ff == ST_DRAIN))
      else $error("dropped item not flagged");

   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && take && (count_ff == CW'(1)))
      |=> (count_ff == '0) && !dropped_ff && rsp_valid_ff && rsp_eor_ff)
      else $error("set not closed after final item");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the insertion sort engine: sets of values in, sorted sets out.
`timescale 1ns / 100ps

module testbench;
   import ise_pkg::*;

   localparam int DEPTH       = 32;
   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VAL_FIELD_W-1:0] value_type;

   typedef struct {
      value_type sorted_value;
      logic      end_of_run;
      logic      overflow;
   } sorted_result_type;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   value_type req_value = '0;
   logic      req_last  = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   value_type rsp_sorted_value;
   logic      rsp_end_of_run;
   logic      rsp_overflow;

   // Mirror of the sorted store, kept ascending.
   value_type         held_values [0:DEPTH-1];
   int                held_count  = 0;
   logic              set_dropped = 1'b0;
   sorted_result_type sorted_results_q[$];

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int rcv_idle_pct   = 0;

   insertion_sort_engine_core #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_overflow     (rsp_overflow)
   );

   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   // Insert after equal values (flag a drop when full); on last, emit the whole store and empty it.
   task automatic predict_sort(input value_type v, input logic is_last);
      sorted_result_type r;
      int pos;
      if (held_count < DEPTH) begin
         pos = held_count;
         while (pos > 0 && held_values[pos-1] > v) begin
            held_values[pos] = held_values[pos-1];
            pos--;
         end
         held_values[pos] = v;
         held_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (is_last) begin
         for (int i = 0; i < held_count; i++) begin
            r.sorted_value = held_values[i];
            r.end_of_run   = (i == held_count - 1);
            r.overflow     = set_dropped;
            sorted_results_q.insert(sorted_results_q.size(), r);
         end
         held_count  = 0;
         set_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      sorted_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_results_q.size() == 0) begin
            $display("%0t: unexpected result value %h eor %b ovf %b", $time,
                     rsp_sorted_value, rsp_end_of_run, rsp_overflow);
            mismatch_count++;
         end else begin
            exp_r = sorted_results_q.pop_front();
            if (rsp_sorted_value !== exp_r.sorted_value) begin
               $display("%0t: sorted_value expected %h actual %h", $time,
                        exp_r.sorted_value, rsp_sorted_value);
               mismatch_count++;
            end
            if (rsp_end_of_run !== exp_r.end_of_run) begin
               $display("%0t: end_of_run expected %b actual %b", $time,
                        exp_r.end_of_run, rsp_end_of_run);
               mismatch_count++;
            end
            if (rsp_overflow !== exp_r.overflow) begin
               $display("%0t: overflow expected %b actual %b", $time,
                        exp_r.overflow, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   // Valid stays high across back-to-back items; lower it only for a gap.
   task automatic send_item(input value_type v, input logic is_last);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= is_last;
      do @(posedge clock); while (req_stall);
      predict_sort(v, is_last);
   endtask

   // Hold the sender until every expected result is out.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sorted_results_q.size() != 0) @(posedge clock);
   endtask

   function automatic value_type pick_value();
      value_type v;
      case ($urandom_range(0, 3))
         0: v = int'($urandom_range(0, 8)) - 4;
         1: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = '0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_set(input int size);
      for (int k = 0; k < size; k++) send_item(pick_value(), k == size - 1);
   endtask

   task automatic test_lone_item();
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sh7FFF_FFFF, 1'b1);
   endtask

   task automatic test_field_extremes();
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh0000_0000, 1'b0);
      send_item(-1, 1'b0);
      send_item(1, 1'b0);
      send_item(32'sh5555_5555, 1'b0);
      send_item(32'shAAAA_AAAA, 1'b1);
   endtask

   task automatic test_equal_values();
      send_item(5, 1'b0);
      send_item(5, 1'b0);
      send_item(-3, 1'b0);
      send_item(5, 1'b0);
      send_item(-3, 1'b1);
   endtask

   // Exactly DEPTH values: full store, no overflow.
   task automatic test_exact_fill();
      send_set(DEPTH);
   endtask

   // Two values beyond DEPTH, both dropped, the last one marked last; then a clean set.
   task automatic test_overflow();
      send_set(DEPTH + 2);
      send_set(3);
   endtask

   task automatic test_random_sets(input int n_items);
      int sent;
      int size;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 8) size = $urandom_range(DEPTH - 2, DEPTH + 6);
         else size = $urandom_range(1, 8);
         send_set(size);
         sent += size;
         if ($urandom_range(0, 99) < 10) wait_results_drained();
      end
   endtask

   initial begin
      send_idle_pct = 37;
      rcv_idle_pct  = 65;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_lone_item();
      test_field_extremes();
      test_equal_values();
      wait_results_drained();
      test_exact_fill();
      test_overflow();
      wait_results_drained();

      test_random_sets(30);
      wait_results_drained();
      send_idle_pct = 65;
      rcv_idle_pct  = 37;
      test_random_sets(28);
      wait_results_drained();
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_random_sets(28);

      wait_results_drained();
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && sorted_results_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
